@@ sv/software_timer_table_top_defines.svh @@
// assertion macros shared by the timer table modules
`ifndef SOFTWARE_TIMER_TABLE_TOP_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define STT_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("stt check failed");
// implication checked in the cycle after the antecedent
`define STT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("stt check failed");
`endif

@@ sv/stt_pkg.sv @@
`default_nettype none
package stt_pkg;
	localparam int unsigned SLOTS_DEF = 16;
	localparam int unsigned MAX_SLOTS = 16;

	typedef enum logic [2:0] {
		ACT_CREATE = 3'd0,
		ACT_DELETE = 3'd1,
		ACT_DELWIN = 3'd2,
		ACT_GETID  = 3'd3,
		ACT_RESET  = 3'd4,
		ACT_TICK   = 3'd5
	} action_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// one slot entry as stored in the memory
	typedef struct packed {
		logic [15:0] window;
		logic [15:0] id;
		logic [23:0] period;
		logic [31:0] deadline;
		logic        one_shot;
	} slot_t;

	// start request and done flag between sequencer and modulo unit
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [23:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic        done;
		logic [23:0] rem;
	} mod_rsp_t;
endpackage
`default_nettype wire

@@ sv/software_timer_table_top.sv @@
// timer slot table: slot fields in one synchronous memory, valid bits in flops
// commands: read, evaluate and output states in turn; delete by window walks all addressable slots
// tick: every slot is read and evaluated; an expiring auto-reload slot also runs the 32-step modulo
// one item at a time; results leave through an output register that can be stalled
// reset: arst_n asynchronously clears valid bits and control; memory needs no clearing
`default_nettype none
module software_timer_table_top #(
	parameter int unsigned SLOTS = stt_pkg::SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  action,
	input  wire logic [3:0]  handle,
	input  wire logic [15:0] window,
	input  wire logic [15:0] timer_id,
	input  wire logic [23:0] period,
	input  wire logic        mode,
	input  wire logic [31:0] now,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic [1:0]       status,
	output logic [3:0]       slot_out,
	output logic [15:0]      window_out,
	output logic [15:0]      id_out,
	output logic             last
);
	import stt_pkg::*;
	`include "software_timer_table_top_defines.svh"

	// only the first sixteen slots are addressable
	localparam int unsigned N  = (SLOTS < MAX_SLOTS) ? SLOTS : MAX_SLOTS;
	localparam int unsigned AW = (N > 1) ? $clog2(N) : 1;

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_RD   = 8'b00000010,
		S_EVAL = 8'b00000100,
		S_MOD  = 8'b00001000,
		S_WB   = 8'b00010000,
		S_OUT  = 8'b00100000,
		S_NEXT = 8'b01000000,
		S_FIN  = 8'b10000000
	} state_t;

	state_t state_q;

	// slot memory with registered read data
	slot_t       mem [N];
	slot_t       rd_q;
	logic        we;
	logic [AW-1:0] wa;
	slot_t       wd;
	logic [AW-1:0] ra;
	logic [N-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	// latched command
	logic [2:0]  act_q;
	logic [3:0]  hnd_q;
	logic [15:0] win_q;
	logic [15:0] tid_q;
	logic [23:0] per_q;
	logic        mode_q;
	logic [31:0] now_q;
	logic [AW-1:0] idx_q;
	logic        any_q;
	logic        hit_q;

	// pending result registered for the output stage
	// during a tick it holds the latest event until it is known whether another follows
	logic        r_kind_q;
	logic [1:0]  r_status_q;
	logic [3:0]  r_slot_q;
	logic [15:0] r_win_q;
	logic [15:0] r_id_q;

	mod_req_t mreq;
	mod_rsp_t mrsp;
	stt_mod u_mod (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	logic hv;
	logic [31:0] diff;
	logic expire;
	logic [N-1:0] free_v;
	logic [AW-1:0] free_i;
	logic is_last;
	logic out_free;
	logic out_load;

	assign hv = ({28'd0, hnd_q} < 32'(N)) && valid_q[hnd_q[AW-1:0]];
	assign diff = now_q - rd_q.deadline;
	// valid slot with nonzero period under the tick scan has reached its deadline
	assign expire = (act_q == ACT_TICK) && valid_q[idx_q] && (rd_q.period != '0) && !diff[31];
	assign is_last = (idx_q == AW'(N - 1));
	assign out_free = !out_valid || !out_stall;
	assign out_load = ((state_q == S_OUT) || (state_q == S_FIN)) && out_free;
	assign in_stall = (state_q != S_IDLE);

	// lowest free slot
	always_comb begin
		free_v = ~valid_q;
		free_i = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (free_v[i]) begin
				free_i = AW'(i);
			end
		end
	end

	assign ra = (state_q == S_IDLE) ? AW'(0) : idx_q;

	always_comb begin
		we = 1'b0;
		wa = idx_q;
		wd = rd_q;
		mreq.start = (state_q == S_EVAL) && expire && !rd_q.one_shot;
		mreq.dividend = diff;
		mreq.divisor = rd_q.period;
		if (state_q == S_WB) begin
			we = hit_q;
			if (rd_q.one_shot) begin
				wd.period = '0;
			end else begin
				wd.deadline = now_q + {8'd0, rd_q.period - mrsp.rem};
			end
		end else if (state_q == S_EVAL && act_q == ACT_CREATE && !(&valid_q)) begin
			we = 1'b1;
			wd.window = win_q;
			wd.id = tid_q;
			wd.period = per_q;
			wd.deadline = now_q + {8'd0, per_q};
			wd.one_shot = mode_q;
		end else if (state_q == S_EVAL && act_q == ACT_RESET && hv) begin
			we = 1'b1;
			wd.period = per_q;
			wd.deadline = now_q + {8'd0, per_q};
		end
	end

	// output valid: set on load, cleared once the transfer happens
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			last <= 1'b0;
			kind <= 1'b0;
			status <= '0;
			slot_out <= '0;
			window_out <= '0;
			id_out <= '0;
			r_kind_q <= 1'b0;
			r_status_q <= '0;
			r_slot_q <= '0;
			r_win_q <= '0;
			r_id_q <= '0;
			any_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						any_q <= 1'b0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					// memory read for idx_q in flight
					state_q <= S_EVAL;
					hit_q <= 1'b0;
				end
				S_EVAL: begin
					if (act_q == ACT_TICK) begin
						if (expire) begin
							hit_q <= 1'b1;
							state_q <= rd_q.one_shot ? S_WB : S_MOD;
						end else begin
							state_q <= is_last ? S_FIN : S_NEXT;
						end
					end else if (act_q == ACT_DELWIN) begin
						if (valid_q[idx_q] && rd_q.window == win_q) begin
							valid_q[idx_q] <= 1'b0;
						end
						state_q <= is_last ? S_FIN : S_NEXT;
					end else begin
						// single-step commands: stage the reply
						r_kind_q <= 1'b0;
						r_win_q <= '0;
						state_q <= S_OUT;
						if (act_q == ACT_CREATE) begin
							r_id_q <= '0;
							if (&valid_q) begin
								r_status_q <= ST_FULL;
								r_slot_q <= '0;
							end else begin
								valid_q[free_i] <= 1'b1;
								r_status_q <= ST_OK;
								r_slot_q <= 4'(free_i);
							end
						end else if (act_q == ACT_DELETE || act_q == ACT_GETID ||
							act_q == ACT_RESET) begin
							r_status_q <= hv ? ST_OK : ST_INVALID;
							r_slot_q <= '0;
							r_id_q <= (act_q == ACT_GETID && hv) ? rd_q.id : '0;
							if (act_q == ACT_DELETE && hv) begin
								valid_q[hnd_q[AW-1:0]] <= 1'b0;
							end
						end else begin
							// unknown action: plain ok reply
							r_status_q <= ST_OK;
							r_slot_q <= '0;
							r_id_q <= '0;
						end
					end
				end
				S_MOD: begin
					if (mrsp.done) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (any_q) begin
						// an earlier event is held: send it first
						state_q <= S_OUT;
					end else begin
						// first expiry of this tick: hold it
						r_kind_q <= 1'b1;
						r_status_q <= ST_OK;
						r_slot_q <= 4'(idx_q);
						r_win_q <= rd_q.window;
						r_id_q <= '0;
						any_q <= 1'b1;
						state_q <= is_last ? S_FIN : S_NEXT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						kind <= r_kind_q;
						status <= r_status_q;
						slot_out <= r_slot_q;
						window_out <= r_win_q;
						id_out <= r_id_q;
						if (act_q == ACT_TICK && r_kind_q) begin
							// another expiry follows, so this event is not the last
							last <= 1'b0;
							r_slot_q <= 4'(idx_q);
							r_win_q <= rd_q.window;
							state_q <= is_last ? S_FIN : S_NEXT;
						end else begin
							last <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_NEXT: begin
					state_q <= S_RD;
				end
				S_FIN: begin
					// tick/delete-by-window wrap-up: held event or done reply, marked last
					if (out_free) begin
						if (act_q == ACT_TICK && any_q) begin
							kind <= r_kind_q;
							status <= r_status_q;
							slot_out <= r_slot_q;
							window_out <= r_win_q;
							id_out <= r_id_q;
						end else begin
							kind <= 1'b0;
							status <= ST_OK;
							slot_out <= '0;
							window_out <= '0;
							id_out <= '0;
						end
						last <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			act_q <= action;
			hnd_q <= handle;
			win_q <= window;
			tid_q <= timer_id;
			per_q <= period;
			mode_q <= mode;
			now_q <= now;
			idx_q <= (action == ACT_RESET || action == ACT_GETID) ?
				handle[AW-1:0] : ((action == ACT_CREATE) ? free_i : AW'(0));
		end else if (state_q == S_NEXT) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	`STT_ASSERT_IMP(a_stall_busy, clk, arst_n, state_q != S_IDLE, in_stall)
	`STT_ASSERT_IMP(a_mod_only, clk, arst_n, mrsp.done, state_q == S_MOD)
	`STT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
endmodule
`default_nettype wire

@@ sv/stt_mod.sv @@
`default_nettype none
// restoring remainder, one dividend bit per cycle
module stt_mod (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  stt_pkg::mod_req_t     req,
	output stt_pkg::mod_rsp_t     rsp
);
	import stt_pkg::*;
	`include "software_timer_table_top_defines.svh"

	logic [31:0] dvd_q;
	logic [23:0] dvs_q;
	logic [24:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [25:0] sh;
	logic [25:0] sub;

	assign sh  = {rem_q, dvd_q[31]};
	assign sub = sh - {2'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= sub[25] ? sh[24:0] : sub[24:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd1);
		end
	end
	assign rsp.done = done_q;
	assign rsp.rem = rem_q[23:0];

	`STT_ASSERT_IMP(a_mod_cnt, clk, arst_n, busy_q, cnt_q != 6'd0)
	`STT_ASSERT_NEXT(a_mod_done, clk, arst_n, busy_q && cnt_q == 6'd1, rsp.done)
	`STT_ASSERT_IMP(a_mod_idle, clk, arst_n, rsp.done, !busy_q)
endmodule
`default_nettype wire
